// ===== rtl/sze_pkg.sv =====
// ----------------------------------------------------------------------------
// sze_pkg: shared types and constants for the sphere zone entry detector
// Field widths, register reset values, register indexes, request modes and
// the table control bundle.
// ----------------------------------------------------------------------------
package sze_pkg;

    // defaults for the top level parameters
    localparam int MAX_ZONES_DEF  = 64;
    localparam int COORD_BITS_DEF = 24;

    // fixed field widths
    localparam int RADIUS_BITS = 24;  // loaded radius, signed
    localparam int RU_W        = 23;  // kept radius, never negative
    localparam int RSQ_W       = 46;  // squared radius, 16 fraction bits
    localparam int MAG_W       = 25;  // clamped axis distance, up to 2^24
    localparam int SQ_W        = 2 * MAG_W;
    localparam int ACC_W       = 50;  // sum of three axis squares < 2^50
    localparam int COOL_W      = 8;
    localparam int DEFR_W      = 21;
    localparam int MAXR_W      = 23;
    localparam int CFG_W       = 23;
    localparam int CFG_IDX_W   = 2;
    localparam int ZI_W        = 6;

    localparam logic [MAG_W-1:0] AXIS_CLAMP = MAG_W'(1) << 24;

    // register reset values
    localparam logic [COOL_W-1:0] COOLDOWN_RST   = COOL_W'(60);
    localparam logic [DEFR_W-1:0] DEF_RADIUS_RST = DEFR_W'(12800);
    localparam logic [MAXR_W-1:0] MAX_RADIUS_RST = MAXR_W'(1280000);

    // register indexes on the write port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COOLDOWN   = 2'd0,
        CFG_DEF_RADIUS = 2'd1,
        CFG_MAX_RADIUS = 2'd2
    } sze_cfg_idx_t;

    // request modes; the spare code does nothing
    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_SPARE = 2'd3
    } sze_mode_t;

    // table access controls
    typedef struct packed {
        logic rd_en;   // registered read of both words
        logic geo_we;  // write center and squared radius
        logic dyn_we;  // write inside flag and cooldown
    } sze_tbl_ctl_t;

endpackage

// ===== rtl/sphere_zone_entry_detector.sv =====
// ----------------------------------------------------------------------------
// sphere_zone_entry_detector: spherical zone entry detector
// Holds a table of spheres; a position request walks the table and reports
// each zone entered while its cooldown is clear.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  in       | in_valid / in_stall   | mode, coord_x/y/z, zone_radius
//  out      | out_valid / out_stall | zone_index, last
//  config   | cfg_we                | cfg_index, cfg_data
//
//  Clear and unused-mode requests finish in the cycle they are accepted.
//  A load makes one pass through the shared squaring unit, then writes the entry.
//  A tick walks the loaded zones: each zone is read from the
//  table, its three axes go one per cycle through the shared two-stage
//  squaring unit, then the sum is compared. in_stall is high until done.
//  A firing waits for the output register when it is still held by out_stall.
//  Reset clears the zone count, the output and the registers to defaults;
//  the table memories are not cleared (every entry is written on load).
//
module sphere_zone_entry_detector #(
    parameter int MAX_ZONES  = sze_pkg::MAX_ZONES_DEF,
    parameter int COORD_BITS = sze_pkg::COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            mode,
    input  logic signed [COORD_BITS-1:0]          coord_x,
    input  logic signed [COORD_BITS-1:0]          coord_y,
    input  logic signed [COORD_BITS-1:0]          coord_z,
    input  logic signed [sze_pkg::RADIUS_BITS-1:0] zone_radius,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [sze_pkg::ZI_W-1:0]              zone_index,
    output logic                                  last,
    // register writes
    input  logic                                  cfg_we,
    input  logic [sze_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sze_pkg::CFG_W-1:0]             cfg_data
);

    localparam int IDX_W = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int CNT_W = $clog2(MAX_ZONES + 1);
    // operand of the squaring unit must hold a coordinate or a radius
    localparam int OP_W  = ((COORD_BITS > sze_pkg::RU_W) ? COORD_BITS
                                                         : sze_pkg::RU_W) + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_SQ,
        ST_LOAD_WR,
        ST_READ,
        ST_FEED,
        ST_ACC,
        ST_DECIDE,
        ST_FLUSH
    } state_t;

    // configuration registers
    logic [sze_pkg::COOL_W-1:0] cooldown_ticks_reg;
    logic [sze_pkg::DEFR_W-1:0] default_radius_reg;
    logic [sze_pkg::MAXR_W-1:0] max_radius_reg;

    // control
    state_t                     state_reg,    state_next;
    logic [CNT_W-1:0]           cnt_reg,      cnt_next;
    logic [IDX_W-1:0]           idx_reg,      idx_next;
    logic [1:0]                 ax_reg,       ax_next;
    logic [1:0]                 sq_cnt_reg,   sq_cnt_next;
    logic [sze_pkg::ACC_W-1:0]  acc_reg,      acc_next;
    logic                       pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]           pend_idx_reg, pend_idx_next;
    logic                       out_vld_reg,  out_vld_next;
    logic [sze_pkg::ZI_W-1:0]   out_idx_reg,  out_idx_next;
    logic                       out_last_reg, out_last_next;

    // request payload held while working
    logic signed [COORD_BITS-1:0] pos_x_reg;
    logic signed [COORD_BITS-1:0] pos_y_reg;
    logic signed [COORD_BITS-1:0] pos_z_reg;
    logic [sze_pkg::RU_W-1:0]     ru_reg;
    logic [sze_pkg::RU_W-1:0]     ru_sel;
    logic                         r_bad;

    logic                       in_acc;
    logic                       out_free;
    logic [CNT_W-1:0]           cnt_m1;
    logic [IDX_W-1:0]           last_idx;

    // squaring unit
    logic                       u_in_valid;
    logic signed [OP_W-1:0]     u_a;
    logic signed [OP_W-1:0]     u_b;
    logic                       u_out_valid;
    logic [sze_pkg::SQ_W-1:0]   u_sq;

    // table
    sze_pkg::sze_tbl_ctl_t      tbl_ctl;
    logic [IDX_W-1:0]           tbl_addr;
    logic                       tbl_wr_inside;
    logic [sze_pkg::COOL_W-1:0] tbl_wr_cool;
    logic [COORD_BITS-1:0]      geo_cx;
    logic [COORD_BITS-1:0]      geo_cy;
    logic [COORD_BITS-1:0]      geo_cz;
    logic [sze_pkg::RSQ_W-1:0]  geo_rsq;
    logic                       dyn_inside;
    logic [sze_pkg::COOL_W-1:0] dyn_cool;

    // per-zone decision
    logic [sze_pkg::COOL_W-1:0] cool_dec;
    logic                       now_inside;
    logic                       fire;
    logic                       decide_go;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_vld_reg || !out_stall;
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign last_idx = cnt_m1[IDX_W-1:0];

    // radius <= 0 or above the maximum falls back to the default
    assign r_bad  = (zone_radius <= 0) ||
                    (zone_radius > $signed({1'b0, max_radius_reg}));
    assign ru_sel = r_bad ? sze_pkg::RU_W'(default_radius_reg)
                          : zone_radius[sze_pkg::RU_W-1:0];

    assign cool_dec   = (dyn_cool != '0) ? (dyn_cool - sze_pkg::COOL_W'(1)) : dyn_cool;
    assign now_inside = (acc_reg < sze_pkg::ACC_W'(geo_rsq));
    assign fire       = !dyn_inside && now_inside && (cool_dec == '0);
    // a second firing can only retire the held one if the output is free
    assign decide_go  = !(fire && pend_vld_reg) || out_free;

    // ------------------------------------------------------------------
    // register writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cooldown_ticks_reg <= sze_pkg::COOLDOWN_RST;
            default_radius_reg <= sze_pkg::DEF_RADIUS_RST;
            max_radius_reg     <= sze_pkg::MAX_RADIUS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sze_pkg::CFG_COOLDOWN:
                    cooldown_ticks_reg <= cfg_data[sze_pkg::COOL_W-1:0];
                sze_pkg::CFG_DEF_RADIUS:
                    default_radius_reg <= cfg_data[sze_pkg::DEFR_W-1:0];
                sze_pkg::CFG_MAX_RADIUS:
                    max_radius_reg     <= cfg_data[sze_pkg::MAXR_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // request payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            pos_x_reg <= coord_x;
            pos_y_reg <= coord_y;
            pos_z_reg <= coord_z;
            ru_reg    <= ru_sel;
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        ax_next       = ax_reg;
        sq_cnt_next   = sq_cnt_reg;
        acc_next      = acc_reg;
        pend_vld_next = pend_vld_reg;
        pend_idx_next = pend_idx_reg;
        out_vld_next  = out_vld_reg;
        out_idx_next  = out_idx_reg;
        out_last_next = out_last_reg;

        u_in_valid    = 1'b0;
        u_a           = '0;
        u_b           = '0;
        tbl_ctl       = '0;
        tbl_addr      = idx_reg;
        tbl_wr_inside = 1'b0;
        tbl_wr_cool   = '0;

        if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end

        // the three axis squares are summed as they come back from the unit
        if (u_out_valid && (state_reg == ST_FEED || state_reg == ST_ACC))
        begin
            acc_next    = acc_reg + sze_pkg::ACC_W'(u_sq);
            sq_cnt_next = sq_cnt_reg + 2'd1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    priority if (mode == sze_pkg::MODE_CLEAR)
                    begin
                        cnt_next = '0;
                    end
                    else if (mode == sze_pkg::MODE_LOAD)
                    begin
                        if (cnt_reg < CNT_W'(MAX_ZONES))
                        begin
                            state_next = ST_LOAD_SQ;
                        end
                    end
                    else if (mode == sze_pkg::MODE_TICK)
                    begin
                        if (cnt_reg != '0)
                        begin
                            idx_next   = '0;
                            state_next = ST_READ;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_LOAD_SQ:
            begin
                u_in_valid = 1'b1;
                u_a        = OP_W'(ru_reg);
                state_next = ST_LOAD_WR;
            end

            ST_LOAD_WR:
            begin
                if (u_out_valid)
                begin
                    tbl_addr       = cnt_reg[IDX_W-1:0];
                    tbl_ctl.geo_we = 1'b1;
                    tbl_ctl.dyn_we = 1'b1;
                    cnt_next       = cnt_reg + CNT_W'(1);
                    state_next     = ST_IDLE;
                end
            end

            ST_READ:
            begin
                tbl_ctl.rd_en = 1'b1;
                acc_next      = '0;
                sq_cnt_next   = '0;
                ax_next       = '0;
                state_next    = ST_FEED;
            end

            ST_FEED:
            begin
                u_in_valid = 1'b1;
                unique case (ax_reg)
                    2'd0:
                    begin
                        u_a = OP_W'(pos_x_reg);
                        u_b = OP_W'($signed(geo_cx));
                    end
                    2'd1:
                    begin
                        u_a = OP_W'(pos_y_reg);
                        u_b = OP_W'($signed(geo_cy));
                    end
                    default:
                    begin
                        u_a = OP_W'(pos_z_reg);
                        u_b = OP_W'($signed(geo_cz));
                    end
                endcase
                ax_next = ax_reg + 2'd1;
                if (ax_reg == 2'd2)
                begin
                    state_next = ST_ACC;
                end
            end

            ST_ACC:
            begin
                if (sq_cnt_reg == 2'd3)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (decide_go)
                begin
                    tbl_ctl.dyn_we = 1'b1;
                    tbl_wr_inside  = now_inside;
                    tbl_wr_cool    = fire ? cooldown_ticks_reg : cool_dec;
                    if (fire)
                    begin
                        // retire the held firing; it is not the last one
                        if (pend_vld_reg)
                        begin
                            out_vld_next  = 1'b1;
                            out_idx_next  = sze_pkg::ZI_W'(pend_idx_reg);
                            out_last_next = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        pend_idx_next = idx_reg;
                    end
                    if (idx_reg == last_idx)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_READ;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!pend_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_idx_next  = sze_pkg::ZI_W'(pend_idx_reg);
                    out_last_next = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            ax_reg       <= '0;
            sq_cnt_reg   <= '0;
            acc_reg      <= '0;
            pend_vld_reg <= 1'b0;
            pend_idx_reg <= '0;
            out_vld_reg  <= 1'b0;
            out_idx_reg  <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
            ax_reg       <= ax_next;
            sq_cnt_reg   <= sq_cnt_next;
            acc_reg      <= acc_next;
            pend_vld_reg <= pend_vld_next;
            pend_idx_reg <= pend_idx_next;
            out_vld_reg  <= out_vld_next;
            out_idx_reg  <= out_idx_next;
            out_last_reg <= out_last_next;
        end
    end

    assign out_valid  = out_vld_reg;
    assign zone_index = out_idx_reg;
    assign last       = out_last_reg;

    // ------------------------------------------------------------------
    // datapath parts
    // ------------------------------------------------------------------
    sze_sq_unit #(
        .OP_W (OP_W)
    ) u_sq_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (u_in_valid),
        .op_a      (u_a),
        .op_b      (u_b),
        .out_valid (u_out_valid),
        .sq        (u_sq)
    );

    sze_zone_table #(
        .MAX_ZONES  (MAX_ZONES),
        .COORD_BITS (COORD_BITS)
    ) u_zone_table (
        .clk       (clk),
        .ctl       (tbl_ctl),
        .addr      (tbl_addr),
        .wr_cx     (pos_x_reg),
        .wr_cy     (pos_y_reg),
        .wr_cz     (pos_z_reg),
        .wr_rsq    (u_sq[sze_pkg::RSQ_W-1:0]),
        .wr_inside (tbl_wr_inside),
        .wr_cool   (tbl_wr_cool),
        .rd_cx     (geo_cx),
        .rd_cy     (geo_cy),
        .rd_cz     (geo_cz),
        .rd_rsq    (geo_rsq),
        .rd_inside (dyn_inside),
        .rd_cool   (dyn_cool)
    );

`ifndef SYNTHESIS
    // table fill never runs past its depth
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_ZONES))
        else $error("zone count above table depth");

    // the walk only visits loaded zones
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_DECIDE) |-> (idx_reg <= last_idx))
        else $error("walk index beyond loaded zones");

    // a decision always sees all three axis squares
    a_three_axes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |-> (sq_cnt_reg == 2'd3))
        else $error("decision before three axis squares");

    // a new result never overwrites one still held by out_stall
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_stall) |=> (out_vld_reg && $stable(out_idx_reg)
                                        && $stable(out_last_reg)))
        else $error("held result overwritten");

    // a firing is held only while a tick walks the table
    a_pend_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg |-> (state_reg == ST_READ || state_reg == ST_FEED ||
                          state_reg == ST_ACC || state_reg == ST_DECIDE ||
                          state_reg == ST_FLUSH))
        else $error("held firing outside a tick");
`endif

endmodule

// ===== rtl/sze_sq_unit.sv =====
// ----------------------------------------------------------------------------
// sze_sq_unit: shared squared-distance unit
// Two stages: clamped |a - b| into a register, then its square.
// ----------------------------------------------------------------------------
module sze_sq_unit #(
    parameter int OP_W = 25
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [OP_W-1:0]        op_a,
    input  logic signed [OP_W-1:0]        op_b,
    output logic                          out_valid,
    output logic [sze_pkg::SQ_W-1:0]      sq
);

    localparam int DW = OP_W + 1;

    logic signed [DW-1:0]          diff;
    logic [DW-1:0]                 diff_u;
    logic [DW-1:0]                 mag;
    logic [sze_pkg::MAG_W-1:0]     mag_next;
    logic [sze_pkg::MAG_W-1:0]     mag_reg;
    logic [sze_pkg::SQ_W-1:0]      sq_next;
    logic [sze_pkg::SQ_W-1:0]      sq_reg;
    logic                          v1_reg;
    logic                          v2_reg;

    assign diff   = DW'(op_a) - DW'(op_b);
    assign diff_u = diff;
    assign mag    = diff_u[DW-1] ? (~diff_u + DW'(1)) : diff_u;

    // saturate far distances at 2^24
    assign mag_next = (mag > DW'(sze_pkg::AXIS_CLAMP)) ? sze_pkg::AXIS_CLAMP
                                                       : mag[sze_pkg::MAG_W-1:0];
    assign sq_next  = sze_pkg::SQ_W'(mag_reg) * sze_pkg::SQ_W'(mag_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        sq_reg  <= sq_next;
    end

    assign out_valid = v2_reg;
    assign sq        = sq_reg;

endmodule

// ===== rtl/sze_zone_table.sv =====
// ----------------------------------------------------------------------------
// sze_zone_table: zone storage
// Geometry word (center, squared radius) and dynamic word (inside flag,
// cooldown), one entry per zone, registered read.
// ----------------------------------------------------------------------------
module sze_zone_table #(
    parameter int MAX_ZONES  = 64,
    parameter int COORD_BITS = 24
) (
    input  logic                                      clk,
    input  sze_pkg::sze_tbl_ctl_t                     ctl,
    input  logic [((MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1)-1:0] addr,
    input  logic [COORD_BITS-1:0]                     wr_cx,
    input  logic [COORD_BITS-1:0]                     wr_cy,
    input  logic [COORD_BITS-1:0]                     wr_cz,
    input  logic [sze_pkg::RSQ_W-1:0]                 wr_rsq,
    input  logic                                      wr_inside,
    input  logic [sze_pkg::COOL_W-1:0]                wr_cool,
    output logic [COORD_BITS-1:0]                     rd_cx,
    output logic [COORD_BITS-1:0]                     rd_cy,
    output logic [COORD_BITS-1:0]                     rd_cz,
    output logic [sze_pkg::RSQ_W-1:0]                 rd_rsq,
    output logic                                      rd_inside,
    output logic [sze_pkg::COOL_W-1:0]                rd_cool
);

    localparam int GEO_W = 3 * COORD_BITS + sze_pkg::RSQ_W;
    localparam int DYN_W = 1 + sze_pkg::COOL_W;

    logic [GEO_W-1:0] geo_mem [MAX_ZONES];
    logic [DYN_W-1:0] dyn_mem [MAX_ZONES];
    logic [GEO_W-1:0] geo_q_reg;
    logic [DYN_W-1:0] dyn_q_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.geo_we)
        begin
            geo_mem[addr] <= {wr_cx, wr_cy, wr_cz, wr_rsq};
        end
        if (ctl.rd_en)
        begin
            geo_q_reg <= geo_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.dyn_we)
        begin
            dyn_mem[addr] <= {wr_inside, wr_cool};
        end
        if (ctl.rd_en)
        begin
            dyn_q_reg <= dyn_mem[addr];
        end
    end

    assign {rd_cx, rd_cy, rd_cz, rd_rsq} = geo_q_reg;
    assign {rd_inside, rd_cool}          = dyn_q_reg;

endmodule

// ===== tb/sphere_zone_entry_detector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_zone_entry_detector_tb: self-checking bench for the zone detector
// Drives clear, load, tick and spare-mode requests through the request
// channel, predicts the zone entries of every tick from a local copy of the
// zone table, and checks each result in order. Covers register settings at
// their extremes, a full table and a long output hold-off.
// ----------------------------------------------------------------------------
module sphere_zone_entry_detector_tb;

    localparam int CLK_PERIOD   = 4;
    localparam int CLK_HALF     = CLK_PERIOD / 2;
    localparam int RESET_CYCLES = 12;
    localparam int MAX_ZONES    = sze_pkg::MAX_ZONES_DEF;
    localparam int CB           = sze_pkg::COORD_BITS_DEF;
    localparam int ZI_W         = sze_pkg::ZI_W;
    localparam int COOL_W       = sze_pkg::COOL_W;
    // room for a tick over a full table, with some margin
    localparam int DRAIN_CYCLES = 8 * MAX_ZONES + 40;
    localparam int HOLD_CYCLES  = 600;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int MAX_SCENES   = 3;

    localparam int C_MAX = 8388607;
    localparam int C_MIN = -8388608;

    typedef struct {
        sze_pkg::sze_mode_t    mode;
        logic signed [CB-1:0]  x;
        logic signed [CB-1:0]  y;
        logic signed [CB-1:0]  z;
        logic signed [CB-1:0]  r;
    } zone_req_t;

    typedef struct {
        logic [ZI_W-1:0] idx;
        logic            last;
    } zone_hit_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [1:0]               mode = sze_pkg::MODE_CLEAR;
    logic signed [CB-1:0]     coord_x = '0;
    logic signed [CB-1:0]     coord_y = '0;
    logic signed [CB-1:0]     coord_z = '0;
    logic signed [sze_pkg::RADIUS_BITS-1:0] zone_radius = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [ZI_W-1:0]          zone_index;
    logic                     last;
    logic                     cfg_we = 1'b0;
    logic [sze_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [sze_pkg::CFG_W-1:0]     cfg_data = '0;

    sphere_zone_entry_detector dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .zone_radius (zone_radius),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .zone_index  (zone_index),
        .last        (last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    zone_req_t pending_reqs[$];     // requests not yet offered
    zone_hit_t expected_hits[$];    // predicted entries, oldest first
    int        reqs_queued   = 0;
    int        reqs_accepted = 0;
    int        hits_predicted = 0;
    int        errors = 0;
    int        hold_requests = 0;   // bumped to ask the receiver for a long hold

    // Local copy of the zone table and of the registers.
    logic signed [CB-1:0] zc_x[MAX_ZONES];
    logic signed [CB-1:0] zc_y[MAX_ZONES];
    logic signed [CB-1:0] zc_z[MAX_ZONES];
    longint unsigned      zr_sq[MAX_ZONES];
    bit                   z_inside[MAX_ZONES];
    bit [COOL_W-1:0]      z_cool[MAX_ZONES];
    int                   z_count = 0;
    logic [COOL_W-1:0]    cool_reload = sze_pkg::COOLDOWN_RST;
    logic [sze_pkg::DEFR_W-1:0] dflt_radius = sze_pkg::DEF_RADIUS_RST;
    logic [sze_pkg::MAXR_W-1:0] max_rad     = sze_pkg::MAX_RADIUS_RST;

    // Squared distance along one axis, capped at 2^24 per axis.
    function automatic longint unsigned axis_sq(input logic signed [CB-1:0] p,
                                                input logic signed [CB-1:0] c);
        longint          d;
        longint unsigned mag;
        d   = longint'(p) - longint'(c);
        mag = (d < 0) ? longint'(-d) : d;
        if (mag > (64'd1 << 24))
            mag = 64'd1 << 24;
        return mag * mag;
    endfunction

    // Applies one accepted request to the table copy and queues the
    // entries that a tick causes, in ascending zone order.
    task automatic predict_zone_hits(input zone_req_t rq);
        longint    rad;
        longint unsigned dsq;
        bit        was;
        int        fired;
        zone_hit_t hit;
        fired = 0;
        case (rq.mode)
            sze_pkg::MODE_CLEAR: z_count = 0;
            sze_pkg::MODE_LOAD:
            begin
                if (z_count < MAX_ZONES)
                begin
                    rad = longint'(rq.r);
                    // non-positive or oversize radius falls back to the default
                    if (rad <= 0 || rad > longint'(max_rad))
                        rad = longint'(dflt_radius);
                    zc_x[z_count]     = rq.x;
                    zc_y[z_count]     = rq.y;
                    zc_z[z_count]     = rq.z;
                    zr_sq[z_count]    = rad * rad;
                    z_inside[z_count] = 1'b0;
                    z_cool[z_count]   = '0;
                    z_count++;
                end
            end
            sze_pkg::MODE_TICK:
            begin
                for (int i = 0; i < z_count; i++)
                begin
                    was = z_inside[i];
                    if (z_cool[i] != 0)
                        z_cool[i]--;
                    dsq = axis_sq(rq.x, zc_x[i]) + axis_sq(rq.y, zc_y[i])
                        + axis_sq(rq.z, zc_z[i]);
                    // strict compare: on the boundary counts as outside
                    z_inside[i] = (dsq < zr_sq[i]);
                    if (!was && z_inside[i] && z_cool[i] == 0)
                    begin
                        z_cool[i] = cool_reload;
                        hit.idx   = ZI_W'(i);
                        hit.last  = 1'b0;
                        expected_hits.push_back(hit);
                        fired++;
                    end
                end
                if (fired > 0)
                    expected_hits[expected_hits.size() - 1].last = 1'b1;
                hits_predicted += fired;
            end
            default: ;  // spare mode: no effect
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request driver: bursts of random length separated by random gaps.
    // A stalled request is held unchanged until accepted.
    // ------------------------------------------------------------------
    zone_req_t cur_req;
    int        burst_left;
    int        gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            mode        <= sze_pkg::MODE_CLEAR;
            coord_x     <= '0;
            coord_y     <= '0;
            coord_z     <= '0;
            zone_radius <= '0;
            burst_left  = 0;
            gap_left    = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_zone_hits(cur_req);
                reqs_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    mode        <= cur_req.mode;
                    coord_x     <= cur_req.x;
                    coord_y     <= cur_req.y;
                    coord_z     <= cur_req.z;
                    zone_radius <= cur_req.r;
                    in_valid    <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        // now and then a long burst with no gaps at all
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(0, 6);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: a random stall style (never, light, heavy) kept for a random
    // stretch. A long hold is started whenever hold_requests moves on.
    // ------------------------------------------------------------------
    int stall_style;
    int style_left;
    int holds_done;
    int hold_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_style = 0;
            style_left  = 0;
            holds_done  = 0;
            hold_left   = 0;
        end
        else
        begin
            if (hold_requests != holds_done)
            begin
                holds_done = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (style_left == 0)
                begin
                    stall_style = $urandom_range(0, 2);
                    style_left  = $urandom_range(16, 96);
                end
                else
                    style_left--;
                case (stall_style)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: every accepted result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        zone_hit_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_hits.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual zone_index=%0d last=%0b",
                         $time, zone_index, last);
                errors++;
            end
            else
            begin
                want = expected_hits.pop_front();
                if (zone_index !== want.idx)
                begin
                    $display("%0t: zone_index mismatch, expected %0d, actual %0d",
                             $time, want.idx, zone_index);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last mismatch, expected %0b, actual %0b",
                             $time, want.last, last);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic zone_req_t mk_req(input sze_pkg::sze_mode_t m,
                                         input int x,
                                         input int y,
                                         input int z,
                                         input int r);
        zone_req_t rq;
        rq.mode = m;
        rq.x    = CB'(x);
        rq.y    = CB'(y);
        rq.z    = CB'(z);
        rq.r    = CB'(r);
        return rq;
    endfunction

    function automatic int rnd_coord();
        return int'($signed(CB'($urandom)));
    endfunction

    task automatic queue_req(input zone_req_t rq);
        pending_reqs.push_back(rq);
        reqs_queued++;
    endtask

    // Registers are only written with the block idle; the mirror follows.
    task automatic write_reg(input sze_pkg::sze_cfg_idx_t idx, input int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= sze_pkg::CFG_W'(val);
        case (idx)
            sze_pkg::CFG_COOLDOWN:   cool_reload = COOL_W'(val);
            sze_pkg::CFG_DEF_RADIUS: dflt_radius = sze_pkg::DEFR_W'(val);
            sze_pkg::CFG_MAX_RADIUS: max_rad     = sze_pkg::MAXR_W'(val);
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_accepted();
        do
            @(posedge clk);
        while (reqs_accepted != reqs_queued);
    endtask

    // All requests taken, all results seen, then room for a silent tick to end.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (reqs_accepted != reqs_queued || expected_hits.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One scene: clear, a handful of zones, then ticks placed mostly around
    // the loaded zones so that entries and exits happen often. A few spare
    // requests, stray loads, early clears and wild positions are mixed in.
    task automatic build_scene(inout int items);
        int sx[16], sy[16], sz[16], sr[16];
        int nz, nt, roll, j, span;
        int r;
        queue_req(mk_req(sze_pkg::MODE_CLEAR, rnd_coord(), rnd_coord(), rnd_coord(),
                         rnd_coord()));
        items++;
        nz = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
        for (int k = 0; k < nz; k++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                sx[k] = rnd_coord();
                sy[k] = rnd_coord();
                sz[k] = rnd_coord();
            end
            else
            begin
                sx[k] = int'($urandom_range(0, 8191)) - 4096;
                sy[k] = int'($urandom_range(0, 8191)) - 4096;
                sz[k] = int'($urandom_range(0, 8191)) - 4096;
            end
            if ($urandom_range(0, 4) == 0)
                r = rnd_coord();
            else
                r = int'($urandom_range(64, 3000));
            // radius the zone ends up with, for aiming the ticks
            sr[k] = (r > 0 && r <= int'(max_rad)) ? r : int'(dflt_radius);
            if (sr[k] < 1)
                sr[k] = 1;
            queue_req(mk_req(sze_pkg::MODE_LOAD, sx[k], sy[k], sz[k], r));
            items++;
        end
        nt = $urandom_range(4, 12);
        for (int k = 0; k < nt; k++)
        begin
            roll = $urandom_range(0, 19);
            if (roll == 0)
                queue_req(mk_req(sze_pkg::MODE_SPARE, rnd_coord(), rnd_coord(),
                                 rnd_coord(), rnd_coord()));
            else
            begin
                if (roll == 1)
                    queue_req(mk_req(sze_pkg::MODE_CLEAR, rnd_coord(), rnd_coord(),
                                     rnd_coord(), rnd_coord()));
                else if (roll == 2)
                    queue_req(mk_req(sze_pkg::MODE_LOAD, rnd_coord(), rnd_coord(),
                                     rnd_coord(), rnd_coord()));
                else if (roll == 3)
                    queue_req(mk_req(sze_pkg::MODE_TICK, rnd_coord(), rnd_coord(),
                                     rnd_coord(), rnd_coord()));
                else
                begin
                    j    = $urandom_range(0, nz - 1);
                    span = ($urandom_range(0, 3) == 0) ? 2 * sr[j] : sr[j];
                    queue_req(mk_req(sze_pkg::MODE_TICK,
                                     sx[j] + int'($urandom_range(0, 2 * span)) - span,
                                     sy[j] + int'($urandom_range(0, 2 * span)) - span,
                                     sz[j] + int'($urandom_range(0, 2 * span)) - span,
                                     rnd_coord()));
                end
                items++;
            end
        end
    endtask

    // Random scenes until enough requests went in and enough entries fired,
    // with a small cap on the number of scenes.
    task automatic run_random_phase(input int min_items, input int min_hits);
        int items, batches, hits_at_start;
        items         = 0;
        batches       = 0;
        hits_at_start = hits_predicted;
        while ((items < min_items || hits_predicted - hits_at_start < min_hits)
               && batches < MAX_SCENES)
        begin
            build_scene(items);
            wait_accepted();
            batches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed, register reset values (cooldown 60, default 50.0,
        //     max 5000.0) ---
        queue_req(mk_req(sze_pkg::MODE_TICK, 0, 0, 0, 0));                   // empty table
        queue_req(mk_req(sze_pkg::MODE_SPARE, -1, -1, -1, -1));              // unused mode
        queue_req(mk_req(sze_pkg::MODE_LOAD, 0, 0, 0, 256));                 // zone 0, r = 1.0
        queue_req(mk_req(sze_pkg::MODE_LOAD, C_MAX, C_MAX, C_MAX, 1280000)); // radius at max
        queue_req(mk_req(sze_pkg::MODE_LOAD, C_MIN, C_MIN, C_MIN, 0));       // zero radius
        queue_req(mk_req(sze_pkg::MODE_LOAD, 1000, 0, 0, -1));               // negative radius
        queue_req(mk_req(sze_pkg::MODE_LOAD, 0, -5000, 0, C_MIN));           // most negative
        queue_req(mk_req(sze_pkg::MODE_LOAD, 0, 0, 5000, 1280001));          // just over max
        queue_req(mk_req(sze_pkg::MODE_LOAD, -3000, 3000, -3000, C_MAX));    // far over max
        queue_req(mk_req(sze_pkg::MODE_LOAD, 100000, 0, 0, 256));            // boundary zone
        queue_req(mk_req(sze_pkg::MODE_TICK, 0, 0, 0, C_MAX));               // several entries
        queue_req(mk_req(sze_pkg::MODE_TICK, C_MIN, C_MIN, C_MIN, 0));       // opposite corner
        queue_req(mk_req(sze_pkg::MODE_TICK, C_MAX, C_MAX, C_MAX, 0));       // widest distances
        queue_req(mk_req(sze_pkg::MODE_TICK, 0, 0, 0, 0));                   // re-entry, cooling
        queue_req(mk_req(sze_pkg::MODE_TICK, 100256, 0, 0, 0));              // on the surface
        queue_req(mk_req(sze_pkg::MODE_TICK, 100255, 0, 0, 0));              // just inside
        queue_req(mk_req(sze_pkg::MODE_CLEAR, C_MAX, C_MIN, C_MAX, C_MIN));
        queue_req(mk_req(sze_pkg::MODE_TICK, 0, 0, 0, 0));                   // nothing loaded
        queue_req(mk_req(sze_pkg::MODE_LOAD, 0, 0, 0, 1));                   // reload slot 0
        queue_req(mk_req(sze_pkg::MODE_TICK, 0, 0, 0, 0));                   // fresh zone fires
        queue_req(mk_req(sze_pkg::MODE_TICK, C_MAX, C_MIN, 0, 0));
        wait_drained();

        // --- no cooldown, default radius zero, max radius one ---
        write_reg(sze_pkg::CFG_COOLDOWN, 0);
        write_reg(sze_pkg::CFG_DEF_RADIUS, 0);
        write_reg(sze_pkg::CFG_MAX_RADIUS, 1);
        queue_req(mk_req(sze_pkg::MODE_CLEAR, 0, 0, 0, 0));
        queue_req(mk_req(sze_pkg::MODE_LOAD, 0, 0, 0, 5));     // takes the zero default
        queue_req(mk_req(sze_pkg::MODE_LOAD, 0, 0, 0, 1));
        queue_req(mk_req(sze_pkg::MODE_TICK, 0, 0, 0, 0));
        queue_req(mk_req(sze_pkg::MODE_TICK, 0, 0, 0, 0));     // still inside
        queue_req(mk_req(sze_pkg::MODE_TICK, 1, 0, 0, 0));     // on the surface: out
        queue_req(mk_req(sze_pkg::MODE_TICK, 0, 0, 0, 0));     // fires again right away
        wait_drained();

        // --- random, short cooldown, default radius 5000.0, largest max radius ---
        write_reg(sze_pkg::CFG_COOLDOWN, 2);
        write_reg(sze_pkg::CFG_DEF_RADIUS, 1280000);
        write_reg(sze_pkg::CFG_MAX_RADIUS, 8388607);
        run_random_phase(10, 3);
        wait_drained();

        // --- random, smallest nonzero default radius, tight max radius ---
        write_reg(sze_pkg::CFG_COOLDOWN, 1);
        write_reg(sze_pkg::CFG_DEF_RADIUS, 1);
        write_reg(sze_pkg::CFG_MAX_RADIUS, 2048);
        run_random_phase(10, 3);
        wait_drained();

        // --- full table, then a long output hold while ticks keep coming ---
        write_reg(sze_pkg::CFG_COOLDOWN, 255);
        write_reg(sze_pkg::CFG_DEF_RADIUS, 12800);
        write_reg(sze_pkg::CFG_MAX_RADIUS, 1280000);
        queue_req(mk_req(sze_pkg::MODE_CLEAR, 0, 0, 0, 0));
        for (int k = 0; k < MAX_ZONES; k++)
            queue_req(mk_req(sze_pkg::MODE_LOAD,
                             int'($urandom_range(0, 1023)) - 512,
                             int'($urandom_range(0, 1023)) - 512,
                             int'($urandom_range(0, 1023)) - 512,
                             (k % 5 == 0) ? 0 : int'($urandom_range(12000, 20000))));
        // table full: these two are dropped
        queue_req(mk_req(sze_pkg::MODE_LOAD, 0, 0, 0, 256));
        queue_req(mk_req(sze_pkg::MODE_LOAD, rnd_coord(), rnd_coord(), rnd_coord(),
                         rnd_coord()));
        wait_accepted();
        hold_requests++;
        queue_req(mk_req(sze_pkg::MODE_TICK, 0, 0, 0, 0));             // every zone fires
        queue_req(mk_req(sze_pkg::MODE_TICK, C_MAX, C_MAX, C_MAX, 0)); // all leave
        queue_req(mk_req(sze_pkg::MODE_TICK, 0, 0, 0, 0));             // back in, cooling
        queue_req(mk_req(sze_pkg::MODE_TICK, 0, 0, C_MIN, 0));
        wait_drained();

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("simulation failed");
        $finish;
    end

endmodule
